>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the CSR builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ECSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ECSR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define ECSR_ASSERT(lbl, prop, msg)
`define ECSR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> sv/ecsr_pkg.sv
// Package with the commands, status codes and sequencer states of the CSR builder.
`timescale 1ns / 1ps
`default_nettype none
package ecsr_pkg;
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_BUILD    = 2'd1;
  localparam logic [1:0] CMD_READ_OFF = 2'd2;
  localparam logic [1:0] CMD_READ_ADJ = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_SPAN      = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_NOT_BUILT = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_CLR,
    S_EREAD,
    S_ELAT,
    S_DREAD,
    S_DUPD,
    S_PREAD,
    S_PWRITE
  } state_e;
endpackage
`default_nettype wire

>>> sv/edge_list_to_csr_builder.sv
// Top level of the edge list to CSR builder with its stores and build sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Add edge answers from the idle state and read commands pass through a read
// wait state. A build clears the degree store over the V vertices of the span,
// counts the degree of each of the E stored edges, forms the prefix sum of the
// offsets, and scatters the edges into the adjacency store; in reverse mode each
// edge is counted and scattered for both of its ends. The degree store has a
// single port pair. The block holds its input stalled while a command is in work.
// Adjacency values are vertex ids relative to the smallest id seen.
module edge_list_to_csr_builder #(
  parameter int MAX_EDGES = 4096,
  parameter int MAX_VERTS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] src_vertex_i,
  input  wire logic [31:0] dst_vertex_i,
  input  wire logic [13:0] entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [13:0]      read_value_o,
  output logic [31:0]      vertex_min_o,
  output logic [10:0]      vertex_count_o,
  output logic [13:0]      edge_total_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i
);
  import ecsr_pkg::*;

  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW = $clog2(MAX_EDGES + 1);
  localparam int VA = $clog2(MAX_VERTS);
  localparam int VW = $clog2(MAX_VERTS + 1);
  localparam int OA = $clog2(MAX_VERTS + 1);
  localparam int OW = $clog2(2 * MAX_EDGES + 1);
  localparam int AA = $clog2(2 * MAX_EDGES);
  localparam int CW = (FW > VW) ? FW : VW;

  logic [31:0] src_mem [MAX_EDGES];
  logic [31:0] dst_mem [MAX_EDGES];
  logic [OW-1:0] deg_mem [MAX_VERTS];
  logic [OW-1:0] off_mem [MAX_VERTS+1];
  logic [VA-1:0] adj_mem [2*MAX_EDGES];

  state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [31:0] min_q, min_d, max_q, max_d;
  logic built_q, built_d;
  logic [VW-1:0] verts_q, verts_d, nv_q, nv_d;
  logic [OW-1:0] edges_q, edges_d, acc_q, acc_d;
  logic rev_cfg_q, rev_q, rev_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic phase_q, phase_d, side_q, side_d;
  logic [VA-1:0] s_q, s_d, d_q, d_d;
  logic [1:0] rcmd_q, rcmd_d;
  logic out_valid_q, out_valid_d;
  logic [2:0] status_q, status_d;
  logic [13:0] value_q, value_d;

  logic edge_we;
  logic [EA-1:0] edge_wa, edge_ra;
  logic [31:0] src_rd, dst_rd;
  logic deg_we;
  logic [VA-1:0] deg_wa, deg_ra;
  logic [OW-1:0] deg_wd, deg_rd;
  logic off_we;
  logic [OA-1:0] off_wa, off_ra;
  logic [OW-1:0] off_wd, off_rd;
  logic adj_we;
  logic [AA-1:0] adj_wa, adj_ra;
  logic [VA-1:0] adj_wd, adj_rd;

  logic in_acc, last_edge, last_vert, second, build_end;
  logic [VA-1:0] node;
  logic [31:0] span;
  logic [CW-1:0] cnt_inc;
  logic [OW-1:0] sum;

  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc = in_valid_i && !in_stall_o;
  assign cnt_inc = cnt_q + CW'(1);
  assign last_edge = (cnt_inc == CW'(fill_q));
  assign last_vert = (cnt_inc == CW'(nv_q));
  assign second = !side_q && rev_q;
  assign build_end = (state_q == S_DUPD) && phase_q && !second && last_edge;
  assign node = side_q ? d_q : s_q;
  assign span = max_q - min_q;
  assign sum = acc_q + deg_rd;

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign read_value_o = value_q;
  assign vertex_min_o = min_q;
  assign vertex_count_o = built_q ? 11'(verts_q) : 11'd0;
  assign edge_total_o = built_q ? 14'(edges_q) : 14'd0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_i)
            CMD_BUILD: begin
              if (fill_q != '0 && span < 32'(MAX_VERTS)) state_d = S_CLR;
            end
            CMD_READ_OFF: begin
              if (built_q && 32'(entry_index_i) <= 32'(verts_q)) state_d = S_RDWAIT;
            end
            CMD_READ_ADJ: begin
              if (built_q && 32'(entry_index_i) < 32'(edges_q)) state_d = S_RDWAIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RDWAIT: state_d = S_IDLE;
      S_CLR: if (last_vert) state_d = S_EREAD;
      S_EREAD: state_d = S_ELAT;
      S_ELAT: state_d = S_DREAD;
      S_DREAD: state_d = S_DUPD;
      S_DUPD: begin
        priority if (second) state_d = S_DREAD;
        else if (!last_edge) state_d = S_EREAD;
        else if (!phase_q) state_d = S_PREAD;
        else state_d = S_IDLE;
      end
      S_PREAD: state_d = S_PWRITE;
      S_PWRITE: state_d = last_vert ? S_EREAD : S_PREAD;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fill_d = fill_q; min_d = min_q; max_d = max_q; built_d = built_q;
    verts_d = verts_q; edges_d = edges_q; nv_d = nv_q; acc_d = acc_q;
    rev_d = rev_q; cnt_d = cnt_q; phase_d = phase_q; side_d = side_q;
    s_d = s_q; d_d = d_q; rcmd_d = rcmd_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q; value_d = value_q;
    edge_we = 1'b0; edge_wa = EA'(fill_q); edge_ra = EA'(cnt_q);
    deg_we = 1'b0; deg_wa = node; deg_wd = '0; deg_ra = node;
    off_we = 1'b0; off_wa = '0; off_wd = '0; off_ra = node;
    adj_we = 1'b0; adj_wa = AA'(off_rd + deg_rd); adj_wd = side_q ? s_q : d_q;
    adj_ra = AA'(entry_index_i);
    unique case (state_q)
      S_IDLE: begin
        off_ra = OA'(entry_index_i);
        if (in_acc) begin
          rcmd_d = cmd_i;
          value_d = '0;
          unique case (cmd_i)
            CMD_ADD: begin
              out_valid_d = 1'b1;
              if (fill_q == FW'(MAX_EDGES)) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_OK;
                edge_we = 1'b1;
                fill_d = fill_q + FW'(1);
                min_d = (src_vertex_i < min_q) ? src_vertex_i : min_q;
                if (dst_vertex_i < min_d) min_d = dst_vertex_i;
                max_d = (src_vertex_i > max_q) ? src_vertex_i : max_q;
                if (dst_vertex_i > max_d) max_d = dst_vertex_i;
                built_d = 1'b0;
              end
            end
            CMD_BUILD: begin
              built_d = 1'b0;
              if (fill_q == '0) begin
                built_d = 1'b1;
                verts_d = '0;
                edges_d = '0;
                off_we = 1'b1;
                out_valid_d = 1'b1;
                status_d = ST_OK;
              end else if (span >= 32'(MAX_VERTS)) begin
                out_valid_d = 1'b1;
                status_d = ST_SPAN;
              end else begin
                nv_d = VW'(span) + VW'(1);
                rev_d = rev_cfg_q;
                cnt_d = '0;
                phase_d = 1'b0;
              end
            end
            default: begin
              if (!built_q) begin
                out_valid_d = 1'b1;
                status_d = ST_NOT_BUILT;
              end else if ((cmd_i == CMD_READ_OFF && 32'(entry_index_i) > 32'(verts_q)) ||
                           (cmd_i == CMD_READ_ADJ && 32'(entry_index_i) >= 32'(edges_q))) begin
                out_valid_d = 1'b1;
                status_d = ST_BAD_INDEX;
              end
            end
          endcase
        end
      end
      S_RDWAIT: begin
        out_valid_d = 1'b1;
        status_d = ST_OK;
        value_d = (rcmd_q == CMD_READ_OFF) ? 14'(off_rd) : 14'(adj_rd);
      end
      S_CLR: begin
        deg_we = 1'b1;
        deg_wa = VA'(cnt_q);
        off_we = 1'b1;
        cnt_d = last_vert ? '0 : cnt_inc;
      end
      S_ELAT: begin
        s_d = VA'(src_rd - min_q);
        d_d = VA'(dst_rd - min_q);
        side_d = 1'b0;
      end
      S_DUPD: begin
        deg_we = 1'b1;
        deg_wd = deg_rd + OW'(1);
        adj_we = phase_q;
        if (second) begin
          side_d = 1'b1;
        end else begin
          cnt_d = last_edge ? '0 : cnt_inc;
          if (last_edge) begin
            if (!phase_q) begin
              acc_d = '0;
            end else begin
              built_d = 1'b1;
              verts_d = nv_q;
              edges_d = acc_q;
              out_valid_d = 1'b1;
              status_d = ST_OK;
              value_d = '0;
            end
          end
        end
      end
      S_PREAD: deg_ra = VA'(cnt_q);
      S_PWRITE: begin
        off_we = 1'b1;
        off_wa = OA'(cnt_inc);
        off_wd = sum;
        deg_we = 1'b1;
        deg_wa = VA'(cnt_q);
        acc_d = sum;
        cnt_d = last_vert ? '0 : cnt_inc;
        if (last_vert) phase_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      src_mem[edge_wa] <= src_vertex_i;
      dst_mem[edge_wa] <= dst_vertex_i;
    end
    src_rd <= src_mem[edge_ra];
    dst_rd <= dst_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (off_we) off_mem[off_wa] <= off_wd;
    off_rd <= off_mem[off_ra];
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      min_q <= '1;
      max_q <= '0;
      built_q <= 1'b0;
      verts_q <= '0;
      edges_q <= '0;
      rev_cfg_q <= 1'b0;
      rev_q <= 1'b0;
      cnt_q <= '0;
      phase_q <= 1'b0;
      side_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      min_q <= min_d;
      max_q <= max_d;
      built_q <= built_d;
      verts_q <= verts_d;
      edges_q <= edges_d;
      if (cfg_we_i) rev_cfg_q <= cfg_wdata_i;
      rev_q <= rev_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
      side_q <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nv_q <= nv_d;
    acc_q <= acc_d;
    s_q <= s_d;
    d_q <= d_d;
    rcmd_q <= rcmd_d;
    status_q <= status_d;
    value_q <= value_d;
  end

  `ECSR_ASSERT(a_busy_stalls, (state_q != S_IDLE) |-> in_stall_o, "busy but not stalled")
  `ECSR_ASSERT(a_fill_bound, fill_q <= FW'(MAX_EDGES), "edge fill beyond store depth")
  `ECSR_ASSERT_NEXT(a_read_result, (state_q == S_RDWAIT), out_valid_o, "read gave no item")
  `ECSR_ASSERT_NEXT(a_build_done, build_end, built_q, "build end did not set built flag")
endmodule
`default_nettype wire
